[rtl/core/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg: shared constants for the first-fit block allocator
// Field widths of the request and result items, heap geometry defaults and
// the header layout used by the allocator core.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

	// Default heap size in bytes.
	localparam int HEAP_BYTES_DEF = 2048;

	// Widths of the item fields.
	localparam int REQ_W  = 12;
	localparam int OFFS_W = 11;
	localparam int SIZE_W = 12;

	// A request of up to 4095 bytes needs at most 513 granules.
	localparam int NEED_W = 10;

	// Granule is 8 bytes, header takes 4 bytes.
	localparam int GRAIN_SH  = 3;
	localparam int HDR_BYTES = 4;
	localparam int GRAIN     = 8;

endpackage : ffba_pkg

`default_nettype wire

[rtl/core/first_fit_block_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top: first-fit allocator over an implicit list
// Walks block headers held in an on-chip store and splits the first free
// block that is strictly larger than the rounded request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready, request_bytes) takes one allocation
//   item at a time. The request grows by a 4-byte header and is rounded up to
//   8 bytes. The output channel (out_valid/out_ready) returns one result item
//   per request: found, block_offset, granted_bytes and remainder_bytes.
//   Each block header read passes through the READ and EVAL states, the one
//   that ends the walk included; on success SPLIT performs the split write,
//   and DONE loads the result register. One item is in flight at a time, and
//   the next item is taken only once the sequencer is back in IDLE after
//   DONE. The walk visits one header at a time through the single read port
//   of the header store.
//   in_ready is high only while the sequencer is idle. A finished result sits
//   in the output register; the next request is taken while it waits, and
//   its own result is held back until the receiver takes the earlier one.
//   Reset: the heap becomes one free block. No clearing pass is needed; a flag
//   marks the first header as unwritten and the end marker slot is fixed.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_top #(
	parameter int HEAP_BYTES = ffba_pkg::HEAP_BYTES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [ffba_pkg::REQ_W-1:0] request_bytes,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           found,
	output logic [ffba_pkg::OFFS_W-1:0]    block_offset,
	output logic [ffba_pkg::SIZE_W-1:0]    granted_bytes,
	output logic [ffba_pkg::SIZE_W-1:0]    remainder_bytes
);

	// Heap geometry derived from the parameter.
	localparam int HEAP_UNITS = HEAP_BYTES / ffba_pkg::GRAIN;
	localparam int DEPTH      = HEAP_UNITS + 1;
	localparam int UW         = $clog2(HEAP_UNITS + 1);
	localparam int EW         = UW + 1;
	localparam int CW         = (UW > ffba_pkg::NEED_W) ? UW : ffba_pkg::NEED_W;
	localparam int ROUND_ADD  = ffba_pkg::HDR_BYTES + ffba_pkg::GRAIN - 1;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_EVAL  = 3'd2;
	localparam logic [2:0] ST_SPLIT = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                  state_q;
	logic [UW-1:0]               addr_q;
	logic [ffba_pkg::NEED_W-1:0] need_q;
	logic [UW-1:0]               rest_q;
	logic                        hit_q;
	logic                        init_q;

	logic [EW-1:0]               mem [DEPTH];
	logic [EW-1:0]               rd_data_q;
	logic                        wr_en;
	logic [UW-1:0]               wr_addr;
	logic [EW-1:0]               wr_data;

	logic [EW-1:0]               entry;
	logic [UW-1:0]               cur_units;
	logic                        cur_used;
	logic                        fits;
	logic [CW-1:0]               diff;
	logic [ffba_pkg::REQ_W:0]    need_sum;
	logic                        out_free;

	logic                        out_valid_q;
	logic                        found_q;
	logic [ffba_pkg::OFFS_W-1:0] offset_q;
	logic [ffba_pkg::SIZE_W-1:0] granted_q;
	logic [ffba_pkg::SIZE_W-1:0] remain_q;

	// Rounded request in granules: (bytes + 4 + 7) / 8.
	assign need_sum = {1'b0, request_bytes} + (ffba_pkg::REQ_W + 1)'(ROUND_ADD);

	// Header seen by the walk. The first header reads as the whole free heap
	// until it is first written, and the end marker slot always reads zero.
	always_comb begin
		if (addr_q == '0 && !init_q) begin
			entry = {UW'(HEAP_UNITS), 1'b0};
		end else if (addr_q == UW'(HEAP_UNITS)) begin
			entry = '0;
		end else begin
			entry = rd_data_q;
		end
	end

	assign cur_units = entry[EW-1:1];
	assign cur_used  = entry[0];
	assign fits      = !cur_used && (CW'(cur_units) > CW'(need_q));
	assign diff      = CW'(cur_units) - CW'(need_q);
	assign out_free  = !out_valid_q || out_ready;

	// Store write port: allocated header first, free remainder next cycle.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = {UW'(need_q), 1'b1};
		if (state_q == ST_EVAL && cur_units != '0 && fits) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SPLIT) begin
			wr_en   = 1'b1;
			wr_addr = addr_q + UW'(need_q);
			wr_data = {rest_q, 1'b0};
		end
	end

	// Header store, one read and one write port, registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[addr_q];
	end

	// Walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			init_q  <= 1'b0;
			hit_q   <= 1'b0;
			addr_q  <= '0;
			need_q  <= '0;
			rest_q  <= '0;
		end else begin
			if (wr_en && wr_addr == '0) begin
				init_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						need_q  <= need_sum[ffba_pkg::REQ_W:ffba_pkg::GRAIN_SH];
						addr_q  <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (cur_units == '0) begin
						hit_q   <= 1'b0;
						state_q <= ST_DONE;
					end else if (fits) begin
						hit_q   <= 1'b1;
						rest_q  <= diff[UW-1:0];
						state_q <= ST_SPLIT;
					end else begin
						addr_q  <= addr_q + cur_units;
						state_q <= ST_READ;
					end
				end
				ST_SPLIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, zero when no block fits.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			found_q <= hit_q;
			if (hit_q) begin
				offset_q  <= ffba_pkg::OFFS_W'({addr_q, 3'b000});
				granted_q <= ffba_pkg::SIZE_W'({need_q, 3'b000});
				remain_q  <= ffba_pkg::SIZE_W'({rest_q, 3'b000});
			end else begin
				offset_q  <= '0;
				granted_q <= '0;
				remain_q  <= '0;
			end
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign block_offset    = offset_q;
	assign granted_bytes   = granted_q;
	assign remainder_bytes = remain_q;

endmodule : first_fit_block_allocator_top

`default_nettype wire

[rtl/core/ffba_checker.sv]
// ----------------------------------------------------------------------------
// ffba_checker: port-level checks for the first-fit block allocator
// Watches the top level's channels and result fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic                        found,
	input wire logic [ffba_pkg::OFFS_W-1:0] block_offset,
	input wire logic [ffba_pkg::SIZE_W-1:0] granted_bytes,
	input wire logic [ffba_pkg::SIZE_W-1:0] remainder_bytes
);

	// A stalled result item holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found)
			&& $stable(block_offset) && $stable(granted_bytes)
			&& $stable(remainder_bytes))
		else $error("result item changed while stalled");

	// A request that fits nothing reports all-zero fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> block_offset == '0 && granted_bytes == '0
			&& remainder_bytes == '0)
		else $error("not-found result carries nonzero fields");

	// Granted blocks are granule aligned in position and size.
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> block_offset[2:0] == 3'b000
			&& granted_bytes[2:0] == 3'b000 && remainder_bytes[2:0] == 3'b000)
		else $error("result not aligned to 8 bytes");

	// The sequencer leaves idle to walk the headers, so the block is busy right after a take.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while the walk runs");

endmodule : ffba_checker

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.found           (found),
	.block_offset    (block_offset),
	.granted_bytes   (granted_bytes),
	.remainder_bytes (remainder_bytes)
);

`default_nettype wire
